@@ design/octmk_pkg.sv @@
package octmk_pkg;

   localparam int DEEPEST_LEVEL = 20;
   localparam int MAX_DIMS      = 3;
   localparam int COORD_W       = 32;
   localparam int SCALE_W       = 32;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int PROD_W        = DIFF_W + SCALE_W + 1;
   localparam int FRAC_W        = 48;
   localparam int LEVEL_W       = 5;
   localparam int DIMS_W        = 2;
   localparam int CELL_W        = 20;
   localparam int KEY_W         = 61;
   localparam int CSR_W         = 32;
   localparam int CSR_INDEX_W   = 3;

   // Level offset (8^l - 1)/7 is the sum of 8^i for i < l: a 001 pattern cut to 3*l bits.
   localparam logic [KEY_W-1:0] OFFSET_PATTERN = 61'h249249249249249;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_ORIGIN_Z   = 3'd2,
      CSR_SCALE_X    = 3'd3,
      CSR_SCALE_Y    = 3'd4,
      CSR_SCALE_Z    = 3'd5,
      CSR_NUM_DIMS   = 3'd6,
      CSR_LIFT_LEVEL = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic [SCALE_W-1:0]        scale_x;
      logic [SCALE_W-1:0]        scale_y;
      logic [SCALE_W-1:0]        scale_z;
      logic [DIMS_W-1:0]         num_dims;
      logic [LEVEL_W-1:0]        lift_level;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  lifted_key;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [CELL_W-1:0] cell_z;
   } result_type;

   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
      if (lvl > LEVEL_W'(DEEPEST_LEVEL)) begin
         return LEVEL_W'(DEEPEST_LEVEL);
      end
      return lvl;
   endfunction

   function automatic logic [KEY_W-1:0] key_offset(input logic [LEVEL_W-1:0] lvl);
      logic [KEY_W-1:0] mask;
      mask = (KEY_W'(1) << (3 * lvl)) - KEY_W'(1);
      return OFFSET_PATTERN & mask;
   endfunction

endpackage

@@ design/octmk_req_if.sv @@
interface octmk_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [octmk_pkg::COORD_W-1:0] coord_x;
   logic signed [octmk_pkg::COORD_W-1:0] coord_y;
   logic signed [octmk_pkg::COORD_W-1:0] coord_z;
   logic [octmk_pkg::LEVEL_W-1:0]        level;
   logic                               with_offset;

   modport source (output valid, coord_x, coord_y, coord_z, level, with_offset, input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, level, with_offset, output ready);
endinterface

@@ design/octmk_rsp_if.sv @@
interface octmk_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [octmk_pkg::KEY_W-1:0]  key;
   logic [octmk_pkg::KEY_W-1:0]  lifted_key;
   logic [octmk_pkg::CELL_W-1:0] cell_x;
   logic [octmk_pkg::CELL_W-1:0] cell_y;
   logic [octmk_pkg::CELL_W-1:0] cell_z;

   modport source (output valid, key, lifted_key, cell_x, cell_y, cell_z, input ready);
   modport sink (input valid, key, lifted_key, cell_x, cell_y, cell_z, output ready);
endinterface

@@ design/octmk_csr.sv @@
module octmk_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [octmk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [octmk_pkg::CSR_W-1:0]       csr_wdata,
   output octmk_pkg::cfg_type                cfg
);

   octmk_pkg::cfg_type cfg_ff;
   octmk_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (octmk_pkg::csr_index_type'(csr_index))
            octmk_pkg::CSR_ORIGIN_X:   cfg_in.origin_x = csr_wdata;
            octmk_pkg::CSR_ORIGIN_Y:   cfg_in.origin_y = csr_wdata;
            octmk_pkg::CSR_ORIGIN_Z:   cfg_in.origin_z = csr_wdata;
            octmk_pkg::CSR_SCALE_X:    cfg_in.scale_x = csr_wdata;
            octmk_pkg::CSR_SCALE_Y:    cfg_in.scale_y = csr_wdata;
            octmk_pkg::CSR_SCALE_Z:    cfg_in.scale_z = csr_wdata;
            octmk_pkg::CSR_NUM_DIMS:   cfg_in.num_dims = csr_wdata[octmk_pkg::DIMS_W-1:0];
            octmk_pkg::CSR_LIFT_LEVEL: cfg_in.lift_level = csr_wdata[octmk_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{num_dims: octmk_pkg::DIMS_W'(octmk_pkg::MAX_DIMS), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/octmk_axis.sv @@
module octmk_axis (
   input  logic                                clock,
   input  logic                                load_diff,
   input  logic                                load_prod,
   input  logic signed [octmk_pkg::COORD_W-1:0] coord,
   input  logic signed [octmk_pkg::COORD_W-1:0] origin,
   input  logic [octmk_pkg::SCALE_W-1:0]        scale,
   output logic [octmk_pkg::CELL_W-1:0]         frac
);

   logic signed [octmk_pkg::DIFF_W-1:0]  diff_ff;
   logic signed [octmk_pkg::DIFF_W-1:0]  diff_in;
   logic signed [octmk_pkg::SCALE_W:0]   scale_s;
   logic signed [octmk_pkg::PROD_W-1:0]  prod;
   logic [octmk_pkg::CELL_W-1:0]         frac_ff;
   logic [octmk_pkg::CELL_W-1:0]         frac_in;

   assign diff_in = octmk_pkg::DIFF_W'(coord) - octmk_pkg::DIFF_W'(origin);
   assign scale_s = $signed({1'b0, scale});
   assign prod    = diff_ff * scale_s;

   // Only product bits 47 down to 28 can reach a cell index at any level.
   assign frac_in = prod[octmk_pkg::FRAC_W-1:octmk_pkg::FRAC_W-octmk_pkg::CELL_W];

   always_ff @(posedge clock) begin
      if (load_diff) begin
         diff_ff <= diff_in;
      end
      if (load_prod) begin
         frac_ff <= frac_in;
      end
   end

   assign frac = frac_ff;

endmodule

@@ design/octmk_keygen.sv @@
module octmk_keygen (
   input  logic [octmk_pkg::CELL_W-1:0]  frac_x,
   input  logic [octmk_pkg::CELL_W-1:0]  frac_y,
   input  logic [octmk_pkg::CELL_W-1:0]  frac_z,
   input  logic [octmk_pkg::LEVEL_W-1:0] level,
   input  logic                          with_offset,
   input  logic [octmk_pkg::DIMS_W-1:0]  num_dims,
   input  logic [octmk_pkg::LEVEL_W-1:0] lift_level,
   output octmk_pkg::result_type         result
);

   logic [octmk_pkg::DIMS_W-1:0]  dims;
   logic [octmk_pkg::LEVEL_W-1:0] lift;
   logic [octmk_pkg::LEVEL_W-1:0] drop;
   logic [octmk_pkg::CELL_W-1:0]  cx;
   logic [octmk_pkg::CELL_W-1:0]  cy;
   logic [octmk_pkg::CELL_W-1:0]  cz;
   logic [octmk_pkg::KEY_W-1:0]   raw;
   logic [octmk_pkg::KEY_W-1:0]   off_level;

   assign dims = (num_dims == '0) ? octmk_pkg::DIMS_W'(1) : num_dims;
   assign lift = octmk_pkg::clamp_level(lift_level);
   assign drop = octmk_pkg::LEVEL_W'(octmk_pkg::CELL_W) - level;

   // The top level bits of the fraction are the cell index; shifting by 20 - level keeps them.
   assign cx = frac_x >> drop;
   assign cy = (dims >= octmk_pkg::DIMS_W'(2)) ? (frac_y >> drop) : '0;
   assign cz = (dims >= octmk_pkg::DIMS_W'(3)) ? (frac_z >> drop) : '0;

   // The last axis in use takes the lowest slot of each 3-bit group.
   always_comb begin
      raw = '0;
      for (int l = 0; l < octmk_pkg::CELL_W; l++) begin
         case (dims)
            octmk_pkg::DIMS_W'(3): begin
               raw[3*l]     = cz[l];
               raw[3*l + 1] = cy[l];
               raw[3*l + 2] = cx[l];
            end
            octmk_pkg::DIMS_W'(2): begin
               raw[3*l]     = cy[l];
               raw[3*l + 1] = cx[l];
            end
            default: begin
               raw[3*l]     = cx[l];
            end
         endcase
      end
   end

   assign off_level = octmk_pkg::key_offset(level);

   always_comb begin
      result.cell_x = cx;
      result.cell_y = cy;
      result.cell_z = cz;
      result.key    = with_offset ? (raw + off_level) : raw;
      if (lift > level) begin
         result.lifted_key = (raw << (3 * (lift - level))) + octmk_pkg::key_offset(lift);
      end else begin
         result.lifted_key = raw + off_level;
      end
   end

endmodule

@@ design/octree_morton_key.sv @@
// Octree Morton key generator.
// A point enters on the req_chan channel (valid/ready) with three Q16.16
// coordinates, a tree level and an offset flag. One result leaves on the
// rsp_chan channel per request: the interleaved cell key (plus the level offset
// when asked), the key lifted to the configured lift level, and the quantized
// cell index of each axis.
// Origins, scales, the number of axes and the lift level are set through the
// csr_ port, one register per write. The user must write them only while no
// request is in flight; the block itself does not enforce this.
// The datapath is a three-stage pipeline: the coordinate differences are
// registered, then the products of the three 33x32 multipliers, then the
// finished result. One request is accepted every cycle unless the full
// pipeline holds; the multipliers set the clock. Each stage advances when
// the one after it is empty or moving, so requests keep flowing into empty
// stages while a result waits on rsp_chan.ready, and the whole pipeline
// holds once every stage is full.
// Reset empties the pipeline and sets origins and scales to zero, three axes
// and lift level zero.
module octree_morton_key (
   input  logic                              clock,
   input  logic                              reset,
   octmk_req_if.sink                         req_chan,
   octmk_rsp_if.source                       rsp_chan,
   input  logic                              csr_write,
   input  logic [octmk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [octmk_pkg::CSR_W-1:0]       csr_wdata
);

   octmk_pkg::cfg_type    cfg;
   octmk_pkg::result_type result_in;
   octmk_pkg::result_type result_ff;

   logic                          diff_valid_ff;
   logic                          prod_valid_ff;
   logic                          rsp_valid_ff;
   logic                          en_diff;
   logic                          en_prod;
   logic                          en_rsp;
   logic [octmk_pkg::LEVEL_W-1:0] level1_ff;
   logic [octmk_pkg::LEVEL_W-1:0] level2_ff;
   logic                          offset1_ff;
   logic                          offset2_ff;
   logic [octmk_pkg::CELL_W-1:0]  frac_x;
   logic [octmk_pkg::CELL_W-1:0]  frac_y;
   logic [octmk_pkg::CELL_W-1:0]  frac_z;

   assign en_rsp  = !rsp_valid_ff || rsp_chan.ready;
   assign en_prod = !prod_valid_ff || en_rsp;
   assign en_diff = !diff_valid_ff || en_prod;

   assign req_chan.ready = en_diff;

   octmk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   octmk_axis u_axis_x (
      .clock     (clock),
      .load_diff (en_diff),
      .load_prod (en_prod),
      .coord     (req_chan.coord_x),
      .origin    (cfg.origin_x),
      .scale     (cfg.scale_x),
      .frac      (frac_x)
   );

   octmk_axis u_axis_y (
      .clock     (clock),
      .load_diff (en_diff),
      .load_prod (en_prod),
      .coord     (req_chan.coord_y),
      .origin    (cfg.origin_y),
      .scale     (cfg.scale_y),
      .frac      (frac_y)
   );

   octmk_axis u_axis_z (
      .clock     (clock),
      .load_diff (en_diff),
      .load_prod (en_prod),
      .coord     (req_chan.coord_z),
      .origin    (cfg.origin_z),
      .scale     (cfg.scale_z),
      .frac      (frac_z)
   );

   octmk_keygen u_keygen (
      .frac_x      (frac_x),
      .frac_y      (frac_y),
      .frac_z      (frac_z),
      .level       (level2_ff),
      .with_offset (offset2_ff),
      .num_dims    (cfg.num_dims),
      .lift_level  (cfg.lift_level),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (en_diff) begin
            diff_valid_ff <= req_chan.valid;
         end
         if (en_prod) begin
            prod_valid_ff <= diff_valid_ff;
         end
         if (en_rsp) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_diff) begin
         level1_ff  <= octmk_pkg::clamp_level(req_chan.level);
         offset1_ff <= req_chan.with_offset;
      end
      if (en_prod) begin
         level2_ff  <= level1_ff;
         offset2_ff <= offset1_ff;
      end
      if (en_rsp) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.key        = result_ff.key;
   assign rsp_chan.lifted_key = result_ff.lifted_key;
   assign rsp_chan.cell_x     = result_ff.cell_x;
   assign rsp_chan.cell_y     = result_ff.cell_y;
   assign rsp_chan.cell_z     = result_ff.cell_z;

endmodule

@@ verif/tb_octree_morton_key.sv @@
`timescale 1ns / 1ps

module tb_octree_morton_key;

   typedef struct packed {
      logic signed [octmk_pkg::COORD_W-1:0] coord_x;
      logic signed [octmk_pkg::COORD_W-1:0] coord_y;
      logic signed [octmk_pkg::COORD_W-1:0] coord_z;
      logic [octmk_pkg::LEVEL_W-1:0]        level;
      logic                                 with_offset;
   } point_type;

   logic clock;
   logic reset;
   logic csr_write;
   logic [octmk_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [octmk_pkg::CSR_W-1:0] csr_wdata;

   octmk_req_if req_chan();
   octmk_rsp_if rsp_chan();

   octree_morton_key dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's registers, kept in step with every csr write.
   logic signed [octmk_pkg::COORD_W-1:0] box_origin [3];
   logic [octmk_pkg::SCALE_W-1:0] box_scale [3];
   logic [octmk_pkg::DIMS_W-1:0] axes_in_use;
   logic [octmk_pkg::LEVEL_W-1:0] sort_level;

   point_type pending_points [$];
   octmk_pkg::result_type expected_keys [$];
   point_type offered_point;
   octmk_pkg::result_type check_want;

   int send_gap;
   int recv_stall;
   int recv_draw;
   int accepted_points;
   int key_errors;
   bit send_idle;
   bit recv_idle;
   logic hold_off;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [octmk_pkg::CELL_W-1:0] cell_index(
         logic signed [octmk_pkg::COORD_W-1:0] coord,
         logic signed [octmk_pkg::COORD_W-1:0] origin,
         logic [octmk_pkg::SCALE_W-1:0] scale, int lvl);
      logic [63:0] diff;
      logic [63:0] prod;
      logic [63:0] window;
      diff = {{32{coord[octmk_pkg::COORD_W-1]}}, coord}
             - {{32{origin[octmk_pkg::COORD_W-1]}}, origin};
      prod = diff * {32'd0, scale};
      window = (prod >> (octmk_pkg::FRAC_W - lvl)) & ((64'd1 << lvl) - 64'd1);
      return window[octmk_pkg::CELL_W-1:0];
   endfunction

   function automatic logic [63:0] offset_at(int lvl);
      return ((64'd1 << (3 * lvl)) - 64'd1) / 64'd7;
   endfunction

   function automatic octmk_pkg::result_type morton_key_of(point_type p);
      int lvl;
      int lift;
      int dims;
      logic [octmk_pkg::CELL_W-1:0] axis_cell [3];
      logic [63:0] raw;
      logic [63:0] key;
      logic [63:0] lifted;
      octmk_pkg::result_type r;
      lvl = (p.level > octmk_pkg::DEEPEST_LEVEL) ? octmk_pkg::DEEPEST_LEVEL : int'(p.level);
      lift = (sort_level > octmk_pkg::DEEPEST_LEVEL) ? octmk_pkg::DEEPEST_LEVEL
                                                      : int'(sort_level);
      dims = (axes_in_use == 0) ? 1 : int'(axes_in_use);
      axis_cell[0] = cell_index(p.coord_x, box_origin[0], box_scale[0], lvl);
      axis_cell[1] = (dims >= 2) ? cell_index(p.coord_y, box_origin[1], box_scale[1], lvl)
                                 : '0;
      axis_cell[2] = (dims >= 3) ? cell_index(p.coord_z, box_origin[2], box_scale[2], lvl)
                                 : '0;
      // The last axis in use lands in the lowest slot of each 3-bit group.
      raw = '0;
      for (int l = 0; l < lvl; l++) begin
         for (int a = 0; a < dims; a++) begin
            raw[3 * l + a] = axis_cell[dims - 1 - a][l];
         end
      end
      key = p.with_offset ? raw + offset_at(lvl) : raw;
      if (lift > lvl) begin
         lifted = (raw << (3 * (lift - lvl))) + offset_at(lift);
      end else begin
         lifted = raw + offset_at(lvl);
      end
      r.key = key[octmk_pkg::KEY_W-1:0];
      r.lifted_key = lifted[octmk_pkg::KEY_W-1:0];
      r.cell_x = axis_cell[0];
      r.cell_y = axis_cell[1];
      r.cell_z = axis_cell[2];
      return r;
   endfunction

   // Request driver; the prediction is taken at the edge where the request is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_keys.insert(expected_keys.size(), morton_key_of(offered_point));
            accepted_points <= accepted_points + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               req_chan.valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (pending_points.size() > 0) begin
               offered_point = pending_points.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.coord_x <= offered_point.coord_x;
               req_chan.coord_y <= offered_point.coord_y;
               req_chan.coord_z <= offered_point.coord_z;
               req_chan.level <= offered_point.level;
               req_chan.with_offset <= offered_point.with_offset;
               send_gap <= send_idle ? $urandom_range(0, 6) : 0;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall <= 0;
      end else if (hold_off) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         recv_draw = recv_idle ? int'($urandom_range(0, 6)) : 0;
         recv_stall <= recv_draw;
         rsp_chan.ready <= (recv_draw == 0);
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_chan.ready <= (recv_stall == 1);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_keys.size() == 0) begin
            key_errors <= key_errors + 1;
            if (key_errors < 10) begin
               $display("unexpected result: key %h lifted %h", rsp_chan.key, rsp_chan.lifted_key);
            end
         end else begin
            check_want = expected_keys.pop_front();
            if (rsp_chan.key !== check_want.key || rsp_chan.lifted_key !== check_want.lifted_key
                || rsp_chan.cell_x !== check_want.cell_x || rsp_chan.cell_y !== check_want.cell_y
                || rsp_chan.cell_z !== check_want.cell_z) begin
               key_errors <= key_errors + 1;
               if (key_errors < 10) begin
                  $display("mismatch: expected key %h lifted %h cells %h %h %h",
                           check_want.key, check_want.lifted_key, check_want.cell_x,
                           check_want.cell_y, check_want.cell_z);
                  $display("          actual   key %h lifted %h cells %h %h %h",
                           rsp_chan.key, rsp_chan.lifted_key, rsp_chan.cell_x,
                           rsp_chan.cell_y, rsp_chan.cell_z);
               end
            end
         end
      end
   end

   // Long hold-off on the result side, so the pipeline fills and stalls new requests.
   initial begin
      hold_off = 1'b0;
      wait (accepted_points >= 370);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (120) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic load_register(octmk_pkg::csr_index_type idx,
                                logic [octmk_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         octmk_pkg::CSR_ORIGIN_X: box_origin[0] = value;
         octmk_pkg::CSR_ORIGIN_Y: box_origin[1] = value;
         octmk_pkg::CSR_ORIGIN_Z: box_origin[2] = value;
         octmk_pkg::CSR_SCALE_X: box_scale[0] = value;
         octmk_pkg::CSR_SCALE_Y: box_scale[1] = value;
         octmk_pkg::CSR_SCALE_Z: box_scale[2] = value;
         octmk_pkg::CSR_NUM_DIMS: axes_in_use = value[octmk_pkg::DIMS_W-1:0];
         octmk_pkg::CSR_LIFT_LEVEL: sort_level = value[octmk_pkg::LEVEL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_box(logic [octmk_pkg::CSR_W-1:0] origin,
                           logic [octmk_pkg::CSR_W-1:0] scale,
                           logic [octmk_pkg::CSR_W-1:0] dims,
                           logic [octmk_pkg::CSR_W-1:0] lift);
      load_register(octmk_pkg::CSR_ORIGIN_X, origin);
      load_register(octmk_pkg::CSR_ORIGIN_Y, origin);
      load_register(octmk_pkg::CSR_ORIGIN_Z, origin);
      load_register(octmk_pkg::CSR_SCALE_X, scale);
      load_register(octmk_pkg::CSR_SCALE_Y, scale);
      load_register(octmk_pkg::CSR_SCALE_Z, scale);
      load_register(octmk_pkg::CSR_NUM_DIMS, dims);
      load_register(octmk_pkg::CSR_LIFT_LEVEL, lift);
      @(negedge clock);
   endtask

   task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, int lvl, bit off);
      point_type p;
      p.coord_x = x;
      p.coord_y = y;
      p.coord_z = z;
      p.level = octmk_pkg::LEVEL_W'(lvl);
      p.with_offset = off;
      pending_points.insert(pending_points.size(), p);
   endtask

   task automatic settle_pipeline();
      while (pending_points.size() != 0 || req_chan.valid || expected_keys.size() != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic logic [31:0] random_scale();
      case ($urandom_range(0, 5))
         0: return 32'hFFFF_FFFF;
         1: return 32'd1 << $urandom_range(0, 31);
         2: return (32'd1 << $urandom_range(8, 31)) | ($urandom & 32'h0000_FFFF);
         default: return $urandom;
      endcase
   endfunction

   // Mostly points just inside the box, where the cell bits carry real content.
   function automatic logic [31:0] random_coord(logic [31:0] origin);
      if ($urandom_range(0, 9) < 4) begin
         return $urandom;
      end
      return origin + $urandom_range(0, 32'h0002_0000);
   endfunction

   initial begin
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.coord_x = '0;
      req_chan.coord_y = '0;
      req_chan.coord_z = '0;
      req_chan.level = '0;
      req_chan.with_offset = 1'b0;
      rsp_chan.ready = 1'b0;
      box_origin = '{default: '0};
      box_scale = '{default: '0};
      axes_in_use = 2'd3;
      sort_level = '0;
      accepted_points = 0;
      key_errors = 0;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: zero scales give zero cells, three axes, no lift.
      queue_point($urandom, $urandom, $urandom, 5, 1);
      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 20, 0);
      settle_pipeline();

      load_box(32'h0, 32'hFFFF_FFFF, 32'd3, 32'd20);
      queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
      queue_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0);
      queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20, 1);
      queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20, 0);
      queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20, 1);
      queue_point($urandom, $urandom, $urandom, 31, 1);
      queue_point($urandom, $urandom, $urandom, 21, 0);
      queue_point(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 10, 1);
      queue_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 5, 0);
      settle_pipeline();

      // Zero axes act as one axis; a lift level past the limit is held at the limit.
      load_box(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd31);
      queue_point(32'h7FFF_FFFF, $urandom, $urandom, 20, 1);
      queue_point($urandom, $urandom, $urandom, 3, 0);
      queue_point($urandom, $urandom, $urandom, 0, 0);
      queue_point($urandom, $urandom, $urandom, 31, 1);
      settle_pipeline();

      load_box(32'h7FFF_FFFF, 32'd1, 32'd2, 32'd7);
      queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7, 1);
      queue_point($urandom, $urandom, $urandom, 10, 0);
      queue_point($urandom, $urandom, $urandom, 2, 1);
      queue_point(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 20, 0);
      settle_pipeline();

      load_box(32'h0, 32'h0001_0000, 32'd1, 32'd0);
      queue_point(32'h00FF_0000, 32'h1, 32'h2, 16, 1);
      queue_point(32'hFF00_0000, $urandom, $urandom, 12, 0);
      queue_point($urandom, $urandom, $urandom, 20, 1);
      settle_pipeline();

      for (int phase = 0; phase < 8; phase++) begin
         send_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         recv_idle = (phase != 0) && ($urandom_range(0, 3) != 0);
         load_register(octmk_pkg::CSR_ORIGIN_X, $urandom);
         load_register(octmk_pkg::CSR_ORIGIN_Y, $urandom);
         load_register(octmk_pkg::CSR_ORIGIN_Z, $urandom);
         load_register(octmk_pkg::CSR_SCALE_X, random_scale());
         load_register(octmk_pkg::CSR_SCALE_Y, random_scale());
         load_register(octmk_pkg::CSR_SCALE_Z, random_scale());
         load_register(octmk_pkg::CSR_NUM_DIMS, $urandom_range(0, 3));
         load_register(octmk_pkg::CSR_LIFT_LEVEL,
                       ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20) : $urandom_range(0, 31));
         @(negedge clock);
         for (int n = 0; n < 100; n++) begin
            queue_point(random_coord(box_origin[0]), random_coord(box_origin[1]),
                        random_coord(box_origin[2]),
                        ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20) : $urandom_range(0, 31),
                        $urandom_range(0, 1));
         end
         settle_pipeline();
      end

      repeat (10) @(posedge clock);
      if (key_errors == 0 && expected_keys.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
